>>> src/apts_pkg.sv
package apts_pkg;

    localparam int PRIO_W         = 6;
    localparam int ID_W           = 16;
    localparam int QUANT_W        = 8;
    localparam int LIST_DEPTH_DEF = 16;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int REG_IDX_W      = PADDR_W - 2;

    typedef logic signed [PRIO_W-1:0] prio_t;

    localparam prio_t PRIO_MIN = -6'sd20;
    localparam prio_t PRIO_MAX = 6'sd20;

    localparam logic [QUANT_W-1:0]   QUANTUM_RESET = 8'd20;
    localparam logic [REG_IDX_W-1:0] REG_QUANTUM   = 1'b0;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_SET_PRIO,
        OP_SELECT,
        OP_TICK
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK,
        STAT_FULL,
        STAT_EMPTY,
        STAT_BAD_PRIO,
        STAT_NOT_FOUND
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_APPEND,
        CELL_SET,
        CELL_SELECT,
        CELL_COMMIT
    } cell_op_t;

    // command broadcast to every cell
    typedef struct packed {
        cell_op_t        op;
        logic [ID_W-1:0] id;
        prio_t           prio;
    } cell_cmd_t;

    // one ready list entry
    typedef struct packed {
        logic [ID_W-1:0] id;
        prio_t           stat;
        prio_t           dyn;
    } entry_t;

    // best candidate carried along the chain during a select
    typedef struct packed {
        prio_t           val;
        logic [ID_W-1:0] id;
        prio_t           stat;
    } carry_t;

    // what a cell reports when the scan token ends in it
    typedef struct packed {
        logic   done;
        logic   hit;
        carry_t carry;
    } report_t;

endpackage

>>> src/apts_cell.sv
module apts_cell
    import apts_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int POS = 0,
    localparam int IDX_W = $clog2(LIST_DEPTH),
    localparam int CNT_W = $clog2(LIST_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [CNT_W-1:0] len,
    input  logic [IDX_W-1:0] best_idx,
    input  logic             tok_in,
    input  carry_t           carry_in,
    input  logic [IDX_W-1:0] carry_idx_in,
    input  entry_t           nb_in,
    output logic             tok_out,
    output carry_t           carry_out,
    output logic [IDX_W-1:0] carry_idx_out,
    output entry_t           entry_out,
    output report_t          report,
    output logic [IDX_W-1:0] report_idx
);

    localparam bit               FIRST   = (POS == 0);
    localparam logic [CNT_W-1:0] POS_CNT = CNT_W'(POS);
    localparam logic [CNT_W-1:0] POS_NXT = CNT_W'(POS + 1);
    localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(POS);

    entry_t           ent_reg, ent_next;
    logic             tok_reg, tok_next;
    carry_t           carry_reg, carry_next;
    logic [IDX_W-1:0] cidx_reg, cidx_next;

    logic             is_last;
    logic             match;
    logic             take;
    carry_t           sel_carry;
    logic [IDX_W-1:0] sel_idx;

    // age by one, clamped at the most urgent level
    function automatic prio_t age_prio(input prio_t p);
        return (p <= PRIO_MIN) ? PRIO_MIN : prio_t'(p - prio_t'(1));
    endfunction

    always_comb
    begin
        is_last = (len == POS_NXT);
        match   = (ent_reg.id == cmd.id);
        take    = FIRST || (ent_reg.dyn < carry_in.val);
        if (take)
        begin
            sel_carry.val  = ent_reg.dyn;
            sel_carry.id   = ent_reg.id;
            sel_carry.stat = ent_reg.stat;
            sel_idx        = POS_IDX;
        end
        else
        begin
            sel_carry = carry_in;
            sel_idx   = carry_idx_in;
        end

        ent_next   = ent_reg;
        tok_next   = 1'b0;
        carry_next = carry_reg;
        cidx_next  = cidx_reg;
        report     = '0;
        report_idx = '0;

        case (cmd.op)
            CELL_APPEND:
            begin
                if (len == POS_CNT)
                begin
                    ent_next.id   = cmd.id;
                    ent_next.stat = cmd.prio;
                    ent_next.dyn  = cmd.prio;
                end
            end
            CELL_SET:
            begin
                if (tok_in)
                begin
                    if (match)
                    begin
                        ent_next.stat = cmd.prio;
                        ent_next.dyn  = cmd.prio;
                        report.done   = 1'b1;
                        report.hit    = 1'b1;
                    end
                    else if (is_last)
                    begin
                        report.done = 1'b1;
                    end
                    else
                    begin
                        tok_next = 1'b1;
                    end
                end
            end
            CELL_SELECT:
            begin
                if (tok_in)
                begin
                    if (is_last)
                    begin
                        report.done  = 1'b1;
                        report.carry = sel_carry;
                        report_idx   = sel_idx;
                    end
                    else
                    begin
                        tok_next   = 1'b1;
                        carry_next = sel_carry;
                        cidx_next  = sel_idx;
                    end
                end
            end
            CELL_COMMIT:
            begin
                // entries ahead of the winner age in place, the rest close the gap
                if (POS_IDX < best_idx)
                begin
                    ent_next.dyn = age_prio(ent_reg.dyn);
                end
                else if (POS_NXT < len)
                begin
                    ent_next.id   = nb_in.id;
                    ent_next.stat = nb_in.stat;
                    ent_next.dyn  = age_prio(nb_in.dyn);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        carry_reg <= carry_next;
        cidx_reg  <= cidx_next;
    end

    assign tok_out       = tok_reg;
    assign carry_out     = carry_reg;
    assign carry_idx_out = cidx_reg;
    assign entry_out     = ent_reg;

endmodule

>>> src/aging_priority_task_scheduler.sv
// ready list task scheduler with priority aging
//
// items come in on item_valid / item_stall with operation, task_number and
// requested_priority; one result per item leaves on result_valid /
// result_stall. a transfer happens on a clock edge with valid high and stall low.
// the list is a row of cells, one entry each; set priority and select pass a
// scan token from cell to cell, one cell per cycle, so their cost follows the
// list position reached.
// append, tick, rejected items and an empty select do not scan; set priority
// ends at the match or the list end; select scans the whole list, then a
// commit step ages and shifts the entries.
// the result register fills as the block returns to idle, before the next item.
// while the receiver stalls, a finished result waits in its register and a
// following item is still taken and worked on; that second result waits in
// the finish state until the register frees up.
// reset empties the list, stops the running task, clears the quantum counter and
// sets quantum_ticks to 20. quantum_ticks is written over the apb port at address
// 0 by the user only while the block is idle; the block does not enforce this.
module aging_priority_task_scheduler
    import apts_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    localparam int IDX_W = $clog2(LIST_DEPTH),
    localparam int CNT_W = $clog2(LIST_DEPTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    // item channel
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [1:0]                operation,
    input  logic [ID_W-1:0]           task_number,
    input  logic signed [PRIO_W-1:0]  requested_priority,
    // result channel
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [2:0]                status,
    output logic                      chosen_valid,
    output logic [ID_W-1:0]           chosen_task,
    output logic signed [PRIO_W-1:0]  chosen_priority,
    output logic                      preempt,
    output logic [CNT_W-1:0]          ready_count
);

    localparam logic [CNT_W-1:0] LEN_FULL = CNT_W'(LIST_DEPTH);

    // control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [QUANT_W-1:0] qleft_reg, qleft_next;
    logic               running_reg, running_next;
    logic [QUANT_W-1:0] quantum_reg;
    logic               start_reg, start_next;
    logic               result_valid_reg, result_valid_next;

    // item held during a scan
    op_t                op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    prio_t              prio_reg, prio_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;

    // result under construction
    status_t            pend_status_reg, pend_status_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]    pend_task_reg, pend_task_next;
    prio_t              pend_prio_reg, pend_prio_next;
    logic               pend_preempt_reg, pend_preempt_next;

    // result register
    status_t            out_status_reg;
    logic               out_valid_reg;
    logic [ID_W-1:0]    out_task_reg;
    prio_t              out_prio_reg;
    logic               out_preempt_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic               accept;
    logic               prio_ok;
    logic               out_free;
    logic               load_out;
    logic               cfg_write;
    op_t                in_op;

    cell_cmd_t          cmd;

    // chain wiring
    logic               tok_in   [LIST_DEPTH];
    logic               tok_out  [LIST_DEPTH];
    carry_t             carry_in [LIST_DEPTH];
    carry_t             carry_out[LIST_DEPTH];
    logic [IDX_W-1:0]   cidx_in  [LIST_DEPTH];
    logic [IDX_W-1:0]   cidx_out [LIST_DEPTH];
    entry_t             nb_in    [LIST_DEPTH];
    entry_t             entry_out[LIST_DEPTH];
    report_t            rep      [LIST_DEPTH];
    logic [IDX_W-1:0]   rep_idx  [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] tok_vec;

    report_t            red;
    logic [IDX_W-1:0]   red_idx;

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign tok_in[g]   = start_reg;
                assign carry_in[g] = '0;
                assign cidx_in[g]  = '0;
            end
            else
            begin : g_link
                assign tok_in[g]   = tok_out[g-1];
                assign carry_in[g] = carry_out[g-1];
                assign cidx_in[g]  = cidx_out[g-1];
            end

            if (g == LIST_DEPTH - 1)
            begin : g_tail
                assign nb_in[g] = '0;
            end
            else
            begin : g_next
                assign nb_in[g] = entry_out[g+1];
            end

            apts_cell #(
                .LIST_DEPTH (LIST_DEPTH),
                .POS        (g)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .cmd           (cmd),
                .len           (len_reg),
                .best_idx      (best_idx_reg),
                .tok_in        (tok_in[g]),
                .carry_in      (carry_in[g]),
                .carry_idx_in  (cidx_in[g]),
                .nb_in         (nb_in[g]),
                .tok_out       (tok_out[g]),
                .carry_out     (carry_out[g]),
                .carry_idx_out (cidx_out[g]),
                .entry_out     (entry_out[g]),
                .report        (rep[g]),
                .report_idx    (rep_idx[g])
            );

            assign tok_vec[g] = tok_out[g];
        end
    endgenerate

    // only the cell holding the token reports, so an or collects it
    always_comb
    begin
        red     = '0;
        red_idx = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            red     = red | rep[i];
            red_idx = red_idx | rep_idx[i];
        end
    end

    // apb register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_QUANTUM);

    always_comb
    begin
        if (paddr[PADDR_W-1:2] == REG_QUANTUM)
        begin
            prdata = PDATA_W'(quantum_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else if (cfg_write)
        begin
            quantum_reg <= pwdata[QUANT_W-1:0];
        end
    end

    // handshake
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;
    assign in_op      = op_t'(operation);
    assign prio_ok    = (requested_priority >= PRIO_MIN) && (requested_priority <= PRIO_MAX);

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        len_next          = len_reg;
        qleft_next        = qleft_reg;
        running_next      = running_reg;
        start_next        = 1'b0;
        op_next           = op_reg;
        id_next           = id_reg;
        prio_next         = prio_reg;
        best_idx_next     = best_idx_reg;
        pend_status_next  = pend_status_reg;
        pend_valid_next   = pend_valid_reg;
        pend_task_next    = pend_task_reg;
        pend_prio_next    = pend_prio_reg;
        pend_preempt_next = pend_preempt_reg;
        load_out          = 1'b0;
        result_valid_next = result_valid_reg && result_stall;

        cmd.op   = CELL_NOP;
        cmd.id   = id_reg;
        cmd.prio = prio_reg;

        case (state_reg)
            S_IDLE:
            begin
                cmd.id   = task_number;
                cmd.prio = requested_priority;
                if (accept)
                begin
                    op_next           = in_op;
                    id_next           = task_number;
                    prio_next         = requested_priority;
                    pend_status_next  = STAT_OK;
                    pend_valid_next   = 1'b0;
                    pend_task_next    = '0;
                    pend_prio_next    = '0;
                    pend_preempt_next = 1'b0;
                    state_next        = S_FINISH;
                    case (in_op)
                        OP_APPEND:
                        begin
                            if (!prio_ok)
                            begin
                                pend_status_next = STAT_BAD_PRIO;
                            end
                            else if (len_reg == LEN_FULL)
                            begin
                                pend_status_next = STAT_FULL;
                            end
                            else
                            begin
                                cmd.op   = CELL_APPEND;
                                len_next = len_reg + CNT_W'(1);
                            end
                        end
                        OP_SET_PRIO:
                        begin
                            if (!prio_ok)
                            begin
                                pend_status_next = STAT_BAD_PRIO;
                            end
                            else if (len_reg == '0)
                            begin
                                pend_status_next = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                start_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        OP_SELECT:
                        begin
                            if (len_reg == '0)
                            begin
                                pend_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                start_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        OP_TICK:
                        begin
                            if (running_reg)
                            begin
                                if (qleft_reg <= QUANT_W'(1))
                                begin
                                    qleft_next        = '0;
                                    running_next      = 1'b0;
                                    pend_preempt_next = 1'b1;
                                end
                                else
                                begin
                                    qleft_next = qleft_reg - QUANT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.op = (op_reg == OP_SELECT) ? CELL_SELECT : CELL_SET;
                if (red.done)
                begin
                    if (op_reg == OP_SELECT)
                    begin
                        best_idx_next   = red_idx;
                        pend_valid_next = 1'b1;
                        pend_task_next  = red.carry.id;
                        pend_prio_next  = red.carry.stat;
                        state_next      = S_COMMIT;
                    end
                    else
                    begin
                        pend_status_next = red.hit ? STAT_OK : STAT_NOT_FOUND;
                        state_next       = S_FINISH;
                    end
                end
            end
            S_COMMIT:
            begin
                cmd.op       = CELL_COMMIT;
                len_next     = len_reg - CNT_W'(1);
                qleft_next   = quantum_reg;
                running_next = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    load_out          = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            len_reg          <= '0;
            qleft_reg        <= '0;
            running_reg      <= 1'b0;
            start_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            len_reg          <= len_next;
            qleft_reg        <= qleft_next;
            running_reg      <= running_next;
            start_reg        <= start_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        id_reg           <= id_next;
        prio_reg         <= prio_next;
        best_idx_reg     <= best_idx_next;
        pend_status_reg  <= pend_status_next;
        pend_valid_reg   <= pend_valid_next;
        pend_task_reg    <= pend_task_next;
        pend_prio_reg    <= pend_prio_next;
        pend_preempt_reg <= pend_preempt_next;
        if (load_out)
        begin
            out_status_reg  <= pend_status_reg;
            out_valid_reg   <= pend_valid_reg;
            out_task_reg    <= pend_task_reg;
            out_prio_reg    <= pend_prio_reg;
            out_preempt_reg <= pend_preempt_reg;
            out_count_reg   <= len_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign status          = out_status_reg;
    assign chosen_valid    = out_valid_reg;
    assign chosen_task     = out_task_reg;
    assign chosen_priority = out_prio_reg;
    assign preempt         = out_preempt_reg;
    assign ready_count     = out_count_reg;

    // at most one scan token in the chain, counting the one about to enter
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({tok_vec, start_reg}))
        else $error("more than one scan token in the cell chain");

    // a scan always has a live token somewhere
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((|tok_vec) || start_reg))
        else $error("scan without a token");

    // list never grows past its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_FULL)
        else $error("ready list length beyond depth");

    // a commit removes an entry, so the list holds one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> (len_reg != '0))
        else $error("commit on an empty list");

    // a new result only comes out of the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !$past(result_valid_reg && result_stall))
            |-> $past(state_reg == S_FINISH))
        else $error("result loaded outside finish state");

endmodule
